// ===== rtl/core/eodd_pkg.sv =====
// Shared constants and codes for the echo object drop detector.
// Used by the channel interfaces, the distance unit and the top level.
`default_nettype none

package eodd_pkg;

    localparam int TIME_W  = 16;
    localparam int DIST_W  = 14;
    localparam int RUN_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_RUN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_RUN  = 2'd2;

    localparam logic [DIST_W-1:0] THRESHOLD_RESET  = 14'd100;
    localparam logic [RUN_W-1:0]  DETECT_RUN_RESET = 5'd10;
    localparam logic [RUN_W-1:0]  CLEAR_RUN_RESET  = 5'd20;
    localparam logic [RUN_W-1:0]  RUN_MAX          = 5'd31;

    // input opcodes
    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_ABORT = 1'b1;

    // distance = width * 10 / 58 = width * 5 / 29
    localparam int MM_NUMER  = 10;
    localparam int MM_DENOM  = 58;
    localparam int DIV_NUM   = MM_NUMER / 2;
    localparam int DIV_DEN   = MM_DENOM / 2;
    localparam int DIV_SHIFT = 24;
    localparam int RECIP_W   = 20;
    localparam int PROD_IN_W = 19;
    // ceil(2^24 / 29); error term 9 keeps the quotient exact for inputs below 2^19
    localparam int DIV_RECIP = ((1 << DIV_SHIFT) + DIV_DEN - 1) / DIV_DEN;

endpackage

`default_nettype wire

// ===== rtl/core/eodd_ifs.sv =====
// Valid/ready channel interfaces: echo items in, results out, register writes.
// Depends on eodd_pkg for field widths.
`default_nettype none

interface eodd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [eodd_pkg::TIME_W-1:0] capture_time;

    modport source (output valid, output opcode, output capture_time, input ready);
    modport sink   (input valid, input opcode, input capture_time, output ready);
endinterface

interface eodd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        pulse_done;
    logic [eodd_pkg::DIST_W-1:0] distance_mm;
    logic                        object_latched;
    logic                        drop_event;
    logic                        clear_event;

    modport source (output valid, output pulse_done, output distance_mm,
                    output object_latched, output drop_event, output clear_event,
                    input ready);
    modport sink   (input valid, input pulse_done, input distance_mm,
                    input object_latched, input drop_event, input clear_event,
                    output ready);
endinterface

interface eodd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [eodd_pkg::CFG_IDX_W-1:0]  index;
    logic [eodd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/eodd_dist_calc.sv =====
// Pulse width to millimetres: width * 10 / 58 by reciprocal multiplication.
// Depends on eodd_pkg for widths and the reciprocal constant.
`default_nettype none

module eodd_dist_calc
(
    input  wire logic [eodd_pkg::TIME_W-1:0] width,
    output logic      [eodd_pkg::DIST_W-1:0] distance
);

    localparam int PROD_W = eodd_pkg::PROD_IN_W + eodd_pkg::RECIP_W;
    localparam logic [eodd_pkg::RECIP_W-1:0] RECIP =
        eodd_pkg::RECIP_W'(eodd_pkg::DIV_RECIP);

    logic [eodd_pkg::PROD_IN_W-1:0] scaled;
    logic [PROD_W-1:0]              prod;

    // width * 5 as shift and add
    assign scaled   = {1'b0, width, 2'b00} + {3'b000, width};
    assign prod     = PROD_W'(scaled) * PROD_W'(RECIP);
    assign distance = prod[eodd_pkg::DIV_SHIFT +: eodd_pkg::DIST_W];

endmodule

`default_nettype wire

// ===== rtl/core/echo_object_drop_detector.sv =====
// Echo object drop detector: an input register, one pass of distance and run
// logic that updates the edge pairing, run counter and latch, and a result register.
// Depends on eodd_pkg, the channel interfaces in eodd_ifs.sv and eodd_dist_calc.
`default_nettype none

// One result word per input word, in order. A word taken into the input
// register moves to the result register when that register is empty or its
// word is taken, and a new word can be taken every cycle while results are
// taken; the edge pairing, run counter and latch close their loop as the word
// moves. The input channel stalls only when both registers are full and the
// result is not taken. The configuration channel is always ready; writes to
// index 3 are dropped. Write registers only while no word is in flight.

module echo_object_drop_detector
(
    input  wire logic clk,
    input  wire logic rst_n,
    eodd_in_if.sink   in_ch,
    eodd_out_if.source out_ch,
    eodd_cfg_if.sink  cfg
);

    // configuration
    logic [eodd_pkg::DIST_W-1:0] threshold_reg;
    logic [eodd_pkg::RUN_W-1:0]  detect_run_reg;
    logic [eodd_pkg::RUN_W-1:0]  clear_run_reg;

    // input register
    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_op_reg;
    logic [eodd_pkg::TIME_W-1:0] s1_time_reg;

    // detector state
    logic                        awaiting_reg, awaiting_next;
    logic [eodd_pkg::TIME_W-1:0] rise_reg, rise_next;
    logic                        latched_reg, latched_next;
    logic [eodd_pkg::RUN_W-1:0]  run_reg, run_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic                        done_reg, done_next;
    logic [eodd_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic                        drop_reg, drop_next;
    logic                        clr_reg, clr_next;

    logic                        accept;
    logic                        advance;
    logic [eodd_pkg::TIME_W-1:0] width;
    logic [eodd_pkg::DIST_W-1:0] pulse_dist;
    logic [eodd_pkg::RUN_W-1:0]  run_bump;

    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign accept      = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;

    assign width    = s1_time_reg - rise_reg;
    assign run_bump = (run_reg == eodd_pkg::RUN_MAX) ? eodd_pkg::RUN_MAX
                                                     : run_reg + 1'b1;

    eodd_dist_calc u_dist
    (
        .width    (width),
        .distance (pulse_dist)
    );

    always_comb
    begin
        awaiting_next = awaiting_reg;
        rise_next     = rise_reg;
        latched_next  = latched_reg;
        run_next      = run_reg;
        done_next     = 1'b0;
        dist_next     = '0;
        drop_next     = 1'b0;
        clr_next      = 1'b0;
        if (s1_op_reg == eodd_pkg::OP_ABORT)
        begin
            run_next     = '0;
            latched_next = 1'b0;
        end
        else if (!awaiting_reg)
        begin
            rise_next     = s1_time_reg;
            awaiting_next = 1'b1;
        end
        else
        begin
            awaiting_next = 1'b0;
            done_next     = 1'b1;
            dist_next     = pulse_dist;
            if (!latched_reg)
            begin
                run_next = (pulse_dist < threshold_reg) ? run_bump : '0;
                if (run_next >= detect_run_reg)
                begin
                    latched_next = 1'b1;
                    run_next     = '0;
                    drop_next    = 1'b1;
                end
            end
            else
            begin
                run_next = (pulse_dist > threshold_reg) ? run_bump : '0;
                if (run_next >= clear_run_reg)
                begin
                    latched_next = 1'b0;
                    run_next     = '0;
                    clr_next     = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= eodd_pkg::THRESHOLD_RESET;
            detect_run_reg <= eodd_pkg::DETECT_RUN_RESET;
            clear_run_reg  <= eodd_pkg::CLEAR_RUN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                eodd_pkg::REG_THRESHOLD:  threshold_reg  <= cfg.data;
                eodd_pkg::REG_DETECT_RUN: detect_run_reg <= cfg.data[eodd_pkg::RUN_W-1:0];
                eodd_pkg::REG_CLEAR_RUN:  clear_run_reg  <= cfg.data[eodd_pkg::RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            awaiting_reg  <= 1'b0;
            rise_reg      <= '0;
            latched_reg   <= 1'b0;
            run_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                awaiting_reg <= awaiting_next;
                rise_reg     <= rise_next;
                latched_reg  <= latched_next;
                run_reg      <= run_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= in_ch.opcode;
            s1_time_reg <= in_ch.capture_time;
        end
        if (advance)
        begin
            done_reg <= done_next;
            dist_reg <= dist_next;
            drop_reg <= drop_next;
            clr_reg  <= clr_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.pulse_done     = done_reg;
    assign out_ch.distance_mm    = dist_reg;
    assign out_ch.object_latched = latched_reg;
    assign out_ch.drop_event     = drop_reg;
    assign out_ch.clear_event    = clr_reg;

`ifndef SYNTHESIS
    // latch shown with a result is the state that result left behind
    a_event_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (drop_reg || clr_reg)
        |-> (drop_reg == latched_reg) && !(drop_reg && clr_reg))
        else $error("event does not match latch state");

    a_no_pulse_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_reg |-> (dist_reg == '0) && !drop_reg && !clr_reg)
        else $error("distance or event without a completed pulse");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_time_reg) && $stable(s1_op_reg))
        else $error("input register changed while stalled");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(latched_reg) && $stable(run_reg) && $stable(awaiting_reg))
        else $error("detector state moved without a word");
`endif

endmodule

`default_nettype wire
